// File: rtl/tcr_pkg.sv
package tcr_pkg;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_t;

  typedef struct packed {
    logic int_ok;
    logic dec_ok;
    logic sci_ok;
    logic hex_ok;
    logic kw_ok;
    logic id_ok;
  } out_t;

  localparam int unsigned KW_COUNT = 4;
  localparam logic [3:0] KW_ALL = 4'hF;
  localparam logic [2:0] KW_POS_MAX = 3'd7;

  localparam logic [1:0] KW_IF    = 2'd0;
  localparam logic [1:0] KW_WHILE = 2'd1;
  localparam logic [1:0] KW_ELSE  = 2'd2;
  localparam logic [1:0] KW_PRINT = 2'd3;

  localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd2, 3'd5, 3'd4, 3'd5};

  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] pos);
    logic [7:0] c;
    c = 8'h00;
    case (k)
      KW_IF: begin
        case (pos)
          3'd0: c = "i";
          3'd1: c = "f";
          default: c = 8'h00;
        endcase
      end
      KW_WHILE: begin
        case (pos)
          3'd0: c = "w";
          3'd1: c = "h";
          3'd2: c = "i";
          3'd3: c = "l";
          3'd4: c = "e";
          default: c = 8'h00;
        endcase
      end
      KW_ELSE: begin
        case (pos)
          3'd0: c = "e";
          3'd1: c = "l";
          3'd2: c = "s";
          3'd3: c = "e";
          default: c = 8'h00;
        endcase
      end
      KW_PRINT: begin
        case (pos)
          3'd0: c = "p";
          3'd1: c = "r";
          3'd2: c = "i";
          3'd3: c = "n";
          3'd4: c = "t";
          default: c = 8'h00;
        endcase
      end
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/token_class_recognizer.sv
// channel   direction  payload            handshake
// in_       input      tcr_pkg::in_t      in_valid / in_stall
// out_      output     tcr_pkg::out_t     out_valid / out_stall
//
// One character per cycle while in_stall is low: a character is registered, the six
// automata advance from it, and a token's result lands in the output register.
// The per-character automaton state update is a loop, a few gate levels deep.
// rst_n (synchronous) returns every automaton to its start state and empties both
// registers. in_stall rises only while a finished result is stalled and the next
// registered character also ends a token.
module token_class_recognizer (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  tcr_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output tcr_pkg::out_t out_data
);

  localparam logic [1:0] INT_START = 2'd0;
  localparam logic [1:0] INT_BODY  = 2'd1;
  localparam logic [1:0] INT_DEAD  = 2'd3;

  localparam logic [2:0] DEC_START = 3'd0;
  localparam logic [2:0] DEC_INT   = 3'd1;
  localparam logic [2:0] DEC_POINT = 3'd2;
  localparam logic [2:0] DEC_FRAC  = 3'd3;
  localparam logic [2:0] DEC_DEAD  = 3'd7;

  localparam logic [2:0] SCI_START = 3'd0;
  localparam logic [2:0] SCI_INT   = 3'd1;
  localparam logic [2:0] SCI_FRAC  = 3'd2;
  localparam logic [2:0] SCI_E     = 3'd3;
  localparam logic [2:0] SCI_SIGN  = 3'd4;
  localparam logic [2:0] SCI_EXP   = 3'd5;
  localparam logic [2:0] SCI_DEAD  = 3'd7;

  localparam logic [1:0] HEX_START = 2'd0;
  localparam logic [1:0] HEX_DIGIT = 2'd1;
  localparam logic [1:0] HEX_END   = 2'd2;
  localparam logic [1:0] HEX_DEAD  = 2'd3;

  localparam logic [1:0] ID_START = 2'd0;
  localparam logic [1:0] ID_BODY  = 2'd1;
  localparam logic [1:0] ID_DEAD  = 2'd3;

  logic         s1_valid_r;
  tcr_pkg::in_t s1_data_r;
  logic         s1_move;

  logic [1:0] int_phase_r, int_phase_nxt;
  logic [2:0] dec_phase_r, dec_phase_nxt;
  logic [2:0] sci_phase_r, sci_phase_nxt;
  logic [1:0] hex_phase_r, hex_phase_nxt;
  logic [1:0] id_phase_r, id_phase_nxt;
  logic [2:0] kw_pos_r, kw_pos_nxt;
  logic [3:0] kw_cand_r, kw_cand_nxt;
  logic       kw_hit;

  logic          out_valid_r, out_valid_nxt;
  tcr_pkg::out_t out_data_r, out_data_nxt;

  logic [7:0] c;
  logic is_dig, is_nz, is_sign, is_upper, is_lower, is_hexd;

  assign c        = s1_data_r.char_code;
  assign is_dig   = (c >= "0") && (c <= "9");
  assign is_nz    = (c >= "1") && (c <= "9");
  assign is_sign  = (c == "+") || (c == "-");
  assign is_upper = (c >= 8'd65) && (c <= 8'd90);
  assign is_lower = (c >= 8'd97) && (c <= 8'd122);
  assign is_hexd  = is_dig || ((c >= 8'd65) && (c <= 8'd70));

  assign s1_move  = s1_valid_r && (!s1_data_r.last_char || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_move;

  always_comb begin
    case (int_phase_r)
      INT_START: int_phase_nxt = (is_sign || is_dig) ? INT_BODY : INT_DEAD;
      INT_BODY:  int_phase_nxt = is_dig ? INT_BODY : INT_DEAD;
      default:   int_phase_nxt = INT_DEAD;
    endcase

    case (dec_phase_r)
      DEC_START: dec_phase_nxt = (is_sign || is_dig) ? DEC_INT : DEC_DEAD;
      DEC_INT:   dec_phase_nxt = is_dig ? DEC_INT : ((c == ".") ? DEC_POINT : DEC_DEAD);
      DEC_POINT: dec_phase_nxt = is_dig ? DEC_FRAC : DEC_DEAD;
      DEC_FRAC:  dec_phase_nxt = is_dig ? DEC_FRAC : DEC_DEAD;
      default:   dec_phase_nxt = DEC_DEAD;
    endcase

    case (sci_phase_r)
      SCI_START: sci_phase_nxt = (is_sign || is_dig) ? SCI_INT : SCI_DEAD;
      SCI_INT:   sci_phase_nxt = is_dig ? SCI_INT : ((c == ".") ? SCI_FRAC : SCI_DEAD);
      SCI_FRAC:  sci_phase_nxt = is_dig ? SCI_FRAC : ((c == "E") ? SCI_E : SCI_DEAD);
      SCI_E:     sci_phase_nxt = is_sign ? SCI_SIGN : (is_nz ? SCI_EXP : SCI_DEAD);
      SCI_SIGN:  sci_phase_nxt = is_nz ? SCI_EXP : SCI_DEAD;
      SCI_EXP:   sci_phase_nxt = is_dig ? SCI_EXP : SCI_DEAD;
      default:   sci_phase_nxt = SCI_DEAD;
    endcase

    case (hex_phase_r)
      HEX_START: hex_phase_nxt = is_hexd ? HEX_DIGIT : HEX_DEAD;
      HEX_DIGIT: hex_phase_nxt = is_hexd ? HEX_DIGIT : ((c == "H") ? HEX_END : HEX_DEAD);
      default:   hex_phase_nxt = HEX_DEAD;
    endcase

    case (id_phase_r)
      ID_START: id_phase_nxt = (is_upper || is_lower) ? ID_BODY : ID_DEAD;
      ID_BODY:  id_phase_nxt = (is_dig || is_upper || is_lower || (c == "_")) ?
                               ID_BODY : ID_DEAD;
      default:  id_phase_nxt = ID_DEAD;
    endcase
  end

  always_comb begin
    kw_cand_nxt = '0;
    kw_hit      = 1'b0;
    for (int k = 0; k < tcr_pkg::KW_COUNT; k++) begin
      if (kw_cand_r[k] && (kw_pos_r < tcr_pkg::KW_LEN[k]) &&
          (tcr_pkg::kw_char(2'(k), kw_pos_r) == c)) begin
        kw_cand_nxt[k] = 1'b1;
        if (kw_pos_r == tcr_pkg::KW_LEN[k] - 3'd1) begin
          kw_hit = 1'b1;
        end
      end
    end
    kw_pos_nxt = (kw_pos_r < tcr_pkg::KW_POS_MAX) ? kw_pos_r + 3'd1 : kw_pos_r;
  end

  always_comb begin
    out_data_nxt.int_ok = (int_phase_nxt == INT_BODY);
    out_data_nxt.dec_ok = (dec_phase_nxt == DEC_FRAC);
    out_data_nxt.sci_ok = (sci_phase_nxt == SCI_EXP);
    out_data_nxt.hex_ok = (hex_phase_nxt == HEX_END);
    out_data_nxt.kw_ok  = kw_hit;
    out_data_nxt.id_ok  = (id_phase_nxt == ID_BODY);

    if (s1_move && s1_data_r.last_char) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      int_phase_r <= INT_START;
      dec_phase_r <= DEC_START;
      sci_phase_r <= SCI_START;
      hex_phase_r <= HEX_START;
      id_phase_r  <= ID_START;
      kw_pos_r    <= '0;
      kw_cand_r   <= tcr_pkg::KW_ALL;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (s1_move) begin
        if (s1_data_r.last_char) begin
          int_phase_r <= INT_START;
          dec_phase_r <= DEC_START;
          sci_phase_r <= SCI_START;
          hex_phase_r <= HEX_START;
          id_phase_r  <= ID_START;
          kw_pos_r    <= '0;
          kw_cand_r   <= tcr_pkg::KW_ALL;
        end else begin
          int_phase_r <= int_phase_nxt;
          dec_phase_r <= dec_phase_nxt;
          sci_phase_r <= sci_phase_nxt;
          hex_phase_r <= hex_phase_nxt;
          id_phase_r  <= id_phase_nxt;
          kw_pos_r    <= kw_pos_nxt;
          kw_cand_r   <= kw_cand_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_data_r <= in_data;
    end
    if (s1_move && s1_data_r.last_char) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/tcr_checker.sv
module tcr_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input tcr_pkg::out_t out_data
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while no result is held");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed or dropped");

  a_kw_is_id: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.kw_ok) |-> out_data.id_ok)
    else $error("keyword not flagged as identifier");

  a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!(out_data.dec_ok && out_data.sci_ok) &&
                   !(out_data.int_ok && out_data.id_ok)))
    else $error("mutually exclusive classes both flagged");

endmodule

bind token_class_recognizer tcr_checker u_tcr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
